@@ sv/bmp_rle_pixel_decoder_defines.svh @@
// Assertion macros for the bitmap run-length decoder.
`ifndef BMP_RLE_PIXEL_DECODER_DEFINES_SVH
`define BMP_RLE_PIXEL_DECODER_DEFINES_SVH
`ifndef SYNTH
`define BRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define BRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BRD_ASSERT_IMP(lbl, ante, cons, msg)
`define BRD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/bmp_rle_pkg.sv @@
// Types, codes and helpers shared by the bitmap run-length decoder.
package bmp_rle_pkg;

  localparam int ADDR_W      = 20;  // write_address port
  localparam int ROWS_W      = 16;  // coded rows counter, wraps
  localparam int ROW_W       = 18;  // signed destination row index
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [7:0] NIB_LO = 8'h0f;
  localparam logic [7:0] NIB_HI = 8'hf0;

  typedef enum logic [2:0] {
    PH_COUNT   = 3'd0,
    PH_VALUE   = 3'd1,
    PH_ESCAPE  = 3'd2,
    PH_DX      = 3'd3,
    PH_DY      = 3'd4,
    PH_LITERAL = 3'd5,
    PH_PAD     = 3'd6,
    PH_HALT    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    REG_PIXEL_MODE    = 2'd0,
    REG_BYTES_PER_ROW = 2'd1,
    REG_ROW_COUNT     = 2'd2,
    REG_BOTTOM_UP     = 2'd3
  } reg_idx_t;

  localparam logic [1:0] KIND_FILL   = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_NIBBLE = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_FIN = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOI   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef struct packed {
    logic        pixel_mode;
    logic [12:0] bytes_per_row;
    logic [12:0] row_count;
    logic        bottom_up;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic              high;
    logic [7:0]        units;
    logic [7:0]        data;
    logic [1:0]        status;
  } result_t;

  // pixel 0 of a 4-bit pair sits in the low half of the byte
  function automatic logic [7:0] swap_nib(input logic [7:0] b);
    swap_nib = ((b & NIB_LO) << 4) | ((b & NIB_HI) >> 4);
  endfunction

endpackage

@@ sv/bmp_rle_pixel_decoder.sv @@
// Top level of the bitmap run-length decoder: registers, input register, parser, result register.
//
//   channel  direction  handshake            payload
//   input    in         in_valid/in_stall    stream_byte, start_of_image
//   result   out        out_valid/out_stall  write_kind .. status
//   config   in         APB psel/penable     paddr, pwdata, prdata
//
// One item per cycle while the result side does not stall; an item waits in the input register
// and its result (if any) is loaded into the result register as the item leaves it.
// The parser step between the two registers sets the rate: the row base is
// registered from the parser's next row count, the buffer limit from the registers.
// Synchronous reset restores the register defaults and the parser's count phase.
// A stalled result holds; the input register keeps its item until the result side frees.
`include "bmp_rle_pixel_decoder_defines.svh"
module bmp_rle_pixel_decoder #(
  parameter int IMAGE_ADDR_BITS = 20,
  parameter int MAX_ROW_BYTES   = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bmp_rle_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [bmp_rle_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bmp_rle_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           stream_byte,
  input  logic                                 start_of_image,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           write_kind,
  output logic [bmp_rle_pkg::ADDR_W-1:0]       write_address,
  output logic                                 start_in_high_nibble,
  output logic [7:0]                           unit_count,
  output logic [7:0]                           write_data,
  output logic [1:0]                           status
);

  localparam int SW     = $clog2(MAX_ROW_BYTES + 1);
  localparam int BASE_W = bmp_rle_pkg::ROW_W + SW + 1;

  bmp_rle_pkg::cfg_t              cfg;
  logic [SW-1:0]                  stride;
  logic signed [BASE_W-1:0]       row_base;
  logic [IMAGE_ADDR_BITS:0]       limit;
  logic [bmp_rle_pkg::ROWS_W-1:0] rows_ahead;

  logic                           ir_valid;
  logic [7:0]                     ir_byte;
  logic                           ir_soi;
  logic                           advance;
  logic                           res_valid;
  bmp_rle_pkg::result_t           res;

  bmp_rle_regs #(
    .IMAGE_ADDR_BITS (IMAGE_ADDR_BITS),
    .MAX_ROW_BYTES   (MAX_ROW_BYTES)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .rows_done (rows_ahead),
    .cfg       (cfg),
    .stride    (stride),
    .row_base  (row_base),
    .limit     (limit)
  );

  bmp_rle_parse #(
    .IMAGE_ADDR_BITS (IMAGE_ADDR_BITS),
    .MAX_ROW_BYTES   (MAX_ROW_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .stride     (stride),
    .row_base   (row_base),
    .limit      (limit),
    .advance    (advance),
    .item_byte  (ir_byte),
    .item_soi   (ir_soi),
    .rows_ahead (rows_ahead),
    .res_valid  (res_valid),
    .res        (res)
  );

  // item moves on whenever the result register is empty or being taken
  assign advance  = ir_valid && (!out_valid || !out_stall);
  assign in_stall = ir_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      ir_valid <= 1'b1;
    end else if (advance) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ir_byte <= stream_byte;
      ir_soi  <= start_of_image;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      write_kind           <= res.kind;
      write_address        <= res.addr;
      start_in_high_nibble <= res.high;
      unit_count           <= res.units;
      write_data           <= res.data;
      status               <= res.status;
    end
  end

  `BRD_ASSERT_IMP(a_stall_full, in_stall, ir_valid, "input stalled with empty register")
  `BRD_ASSERT_NXT(a_hold_item, ir_valid && out_valid && out_stall, ir_valid && $stable(ir_byte), "held item lost while result stalled")
  `BRD_ASSERT_NXT(a_hold_result, out_valid && out_stall, out_valid && $stable(write_address) && $stable(write_data), "stalled result changed")

endmodule

@@ sv/bmp_rle_regs.sv @@
// Configuration registers and the row geometry derived from them.
module bmp_rle_regs #(
  parameter int IMAGE_ADDR_BITS = 20,
  parameter int MAX_ROW_BYTES   = 4096,
  localparam int SW     = $clog2(MAX_ROW_BYTES + 1),
  localparam int BASE_W = bmp_rle_pkg::ROW_W + SW + 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bmp_rle_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [bmp_rle_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bmp_rle_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                  pready,
  input  logic [bmp_rle_pkg::ROWS_W-1:0]        rows_done,
  output bmp_rle_pkg::cfg_t                     cfg,
  output logic [SW-1:0]                         stride,
  output logic signed [BASE_W-1:0]              row_base,
  output logic [IMAGE_ADDR_BITS:0]              limit
);

  localparam int LP_W = 13 + SW;
  localparam int LW   = (LP_W > IMAGE_ADDR_BITS + 1) ? LP_W : IMAGE_ADDR_BITS + 1;

  bmp_rle_pkg::reg_idx_t    idx;
  logic                     wr_en;
  logic                     sat;
  logic signed [BASE_W-1:0] row_s;
  logic signed [BASE_W-1:0] stride_s;
  logic [LP_W-1:0]          area;
  logic [LW-1:0]            area_ext;
  logic [LW-1:0]            cap;

  assign idx    = bmp_rle_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_mode    <= 1'b0;
      cfg.bytes_per_row <= 13'd320;
      cfg.row_count     <= 13'd240;
      cfg.bottom_up     <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        bmp_rle_pkg::REG_PIXEL_MODE:    cfg.pixel_mode    <= pwdata[0];
        bmp_rle_pkg::REG_BYTES_PER_ROW: cfg.bytes_per_row <= pwdata[12:0];
        bmp_rle_pkg::REG_ROW_COUNT:     cfg.row_count     <= pwdata[12:0];
        bmp_rle_pkg::REG_BOTTOM_UP:     cfg.bottom_up     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bmp_rle_pkg::REG_PIXEL_MODE:    prdata = 32'(cfg.pixel_mode);
      bmp_rle_pkg::REG_BYTES_PER_ROW: prdata = 32'(cfg.bytes_per_row);
      bmp_rle_pkg::REG_ROW_COUNT:     prdata = 32'(cfg.row_count);
      bmp_rle_pkg::REG_BOTTOM_UP:     prdata = 32'(cfg.bottom_up);
      default:                        prdata = '0;
    endcase
  end

  assign sat    = ({2'b00, cfg.bytes_per_row} > 15'(MAX_ROW_BYTES));
  assign stride = sat ? SW'(MAX_ROW_BYTES) : SW'(cfg.bytes_per_row);

  // destination row of the current coded row; negative once bottom-up overruns
  always_comb begin
    if (cfg.bottom_up) begin
      row_s = $signed(BASE_W'(cfg.row_count)) - $signed(BASE_W'(1))
              - $signed(BASE_W'(rows_done));
    end else begin
      row_s = $signed(BASE_W'(rows_done));
    end
    stride_s = $signed(BASE_W'(stride));
  end

  assign area     = LP_W'(cfg.row_count) * LP_W'(stride);
  assign area_ext = LW'(area);
  assign cap      = LW'(1) << IMAGE_ADDR_BITS;

  // rows_done here is the parser's count for the next cycle, so row_base lines up
  // with the parser's own counter; row_base and limit are both registered
  always_ff @(posedge clk) begin
    row_base <= row_s * stride_s;
    limit    <= (area_ext > cap) ? cap[IMAGE_ADDR_BITS:0] : area_ext[IMAGE_ADDR_BITS:0];
  end

endmodule

@@ sv/bmp_rle_parse.sv @@
// Stream parser: phase state, row position and at most one write command per item.
`include "bmp_rle_pixel_decoder_defines.svh"
module bmp_rle_parse #(
  parameter int IMAGE_ADDR_BITS = 20,
  parameter int MAX_ROW_BYTES   = 4096,
  localparam int SW     = $clog2(MAX_ROW_BYTES + 1),
  localparam int BASE_W = bmp_rle_pkg::ROW_W + SW + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bmp_rle_pkg::cfg_t              cfg,
  input  logic [SW-1:0]                  stride,
  input  logic signed [BASE_W-1:0]       row_base,
  input  logic [IMAGE_ADDR_BITS:0]       limit,
  input  logic                           advance,
  input  logic [7:0]                     item_byte,
  input  logic                           item_soi,
  output logic [bmp_rle_pkg::ROWS_W-1:0] rows_ahead,
  output logic                           res_valid,
  output bmp_rle_pkg::result_t           res
);

  localparam int OFF_W = $clog2(MAX_ROW_BYTES + 256);
  localparam int BW    = (BASE_W > IMAGE_ADDR_BITS + 1) ? BASE_W : IMAGE_ADDR_BITS + 1;
  localparam int END_W = BW + 2;

  bmp_rle_pkg::phase_t           phase, phase_next, c_phase;
  logic [7:0]                    run_count, run_next, c_run;
  logic [7:0]                    literal_left, lit_next, c_lit;
  logic [7:0]                    delta_dx, dx_next, c_dx;
  logic                          column_odd, col_next, c_col;
  logic [OFF_W-1:0]              row_offset, off_next, c_off;
  logic [bmp_rle_pkg::ROWS_W-1:0] rows_done, rows_next, c_rows;

  logic                          four;
  logic                          put_req;
  logic                          do_check;
  logic                          drop;
  logic [1:0]                    p_kind;
  logic [7:0]                    p_span;
  logic                          p_high;
  logic [7:0]                    p_units;
  logic [7:0]                    p_data;
  logic [1:0]                    st;
  logic [8:0]                    pn, pn_up, n_up, b_up;
  logic signed [END_W-1:0]       a_s, end_s;

  assign four = cfg.pixel_mode;

  always_comb begin
    // start of image restarts the parser before this byte is taken
    c_phase = item_soi ? bmp_rle_pkg::PH_COUNT : phase;
    c_run   = item_soi ? 8'd0 : run_count;
    c_lit   = item_soi ? 8'd0 : literal_left;
    c_dx    = item_soi ? 8'd0 : delta_dx;
    c_col   = item_soi ? 1'b0 : column_odd;
    c_off   = item_soi ? '0 : row_offset;
    c_rows  = item_soi ? '0 : rows_done;

    phase_next = c_phase;
    run_next   = c_run;
    lit_next   = c_lit;
    dx_next    = c_dx;
    col_next   = c_col;
    off_next   = c_off;
    rows_next  = c_rows;

    res_valid = 1'b0;
    put_req   = 1'b0;
    do_check  = 1'b0;
    p_kind    = bmp_rle_pkg::KIND_NONE;
    p_span    = 8'd0;
    p_high    = 1'b0;
    p_units   = 8'd0;
    p_data    = 8'd0;
    st        = bmp_rle_pkg::ST_RUN;

    pn    = 9'(c_col) + 9'(c_run);
    pn_up = pn + 9'd1;
    n_up  = 9'(c_run) + 9'd1;
    b_up  = 9'(item_byte) + 9'd1;

    case (c_phase)
      bmp_rle_pkg::PH_COUNT: begin
        run_next   = item_byte;
        phase_next = (item_byte != 8'd0) ? bmp_rle_pkg::PH_VALUE : bmp_rle_pkg::PH_ESCAPE;
      end
      bmp_rle_pkg::PH_VALUE: begin
        res_valid = 1'b1;
        put_req   = 1'b1;
        p_kind    = bmp_rle_pkg::KIND_FILL;
        p_units   = c_run;
        if (!four) begin
          p_span   = c_run;
          p_data   = item_byte;
          off_next = c_off + OFF_W'(c_run);
        end else begin
          p_span   = pn_up[8:1];
          p_high   = c_col;
          p_data   = bmp_rle_pkg::swap_nib(item_byte);
          off_next = c_off + OFF_W'(pn[8:1]);
          col_next = pn[0];
        end
        phase_next = bmp_rle_pkg::PH_COUNT;
        do_check   = 1'b1;
      end
      bmp_rle_pkg::PH_ESCAPE: begin
        if (item_byte == bmp_rle_pkg::ESC_EOL) begin
          rows_next  = c_rows + 16'd1;
          off_next   = '0;
          col_next   = 1'b0;
          phase_next = bmp_rle_pkg::PH_COUNT;
          if (rows_next == 16'(cfg.row_count)) begin
            phase_next = bmp_rle_pkg::PH_HALT;
            res_valid  = 1'b1;
            st         = bmp_rle_pkg::ST_FIN;
          end
        end else if (item_byte == bmp_rle_pkg::ESC_EOI) begin
          phase_next = bmp_rle_pkg::PH_HALT;
          res_valid  = 1'b1;
          st         = bmp_rle_pkg::ST_FIN;
        end else if (item_byte == bmp_rle_pkg::ESC_DELTA) begin
          phase_next = bmp_rle_pkg::PH_DX;
        end else begin
          run_next   = item_byte;
          lit_next   = four ? b_up[8:1] : item_byte;
          phase_next = bmp_rle_pkg::PH_LITERAL;
        end
      end
      bmp_rle_pkg::PH_DX: begin
        dx_next    = item_byte;
        phase_next = bmp_rle_pkg::PH_DY;
      end
      bmp_rle_pkg::PH_DY: begin
        off_next   = c_off + OFF_W'(c_dx);
        col_next   = c_col ^ c_dx[0];
        rows_next  = c_rows + 16'(item_byte);
        phase_next = bmp_rle_pkg::PH_COUNT;
        do_check   = 1'b1;
      end
      bmp_rle_pkg::PH_LITERAL: begin
        res_valid = 1'b1;
        put_req   = 1'b1;
        p_span    = 8'd1;
        if (!four) begin
          p_kind   = bmp_rle_pkg::KIND_BYTE;
          p_units  = 8'd1;
          p_data   = item_byte;
          off_next = c_off + OFF_W'(1);
        end else if ((c_lit <= 8'd1) && c_run[0]) begin
          // trailing odd nibble: the only literal case in which the column parity moves
          p_kind  = bmp_rle_pkg::KIND_NIBBLE;
          p_high  = c_col;
          p_units = 8'd1;
          p_data  = bmp_rle_pkg::swap_nib(item_byte);
          if (c_col) begin
            off_next = c_off + OFF_W'(1);
            col_next = 1'b0;
          end else begin
            col_next = 1'b1;
          end
        end else begin
          // whole byte at the current byte, parity left alone
          p_kind   = bmp_rle_pkg::KIND_BYTE;
          p_units  = 8'd2;
          p_data   = bmp_rle_pkg::swap_nib(item_byte);
          off_next = c_off + OFF_W'(1);
        end
        if (c_lit != 8'd0) begin
          lit_next = c_lit - 8'd1;
        end
        if (c_lit <= 8'd1) begin
          if (four ? n_up[1] : c_run[0]) begin
            phase_next = bmp_rle_pkg::PH_PAD;
          end else begin
            phase_next = bmp_rle_pkg::PH_COUNT;
            do_check   = 1'b1;
          end
        end
      end
      bmp_rle_pkg::PH_PAD: begin
        phase_next = bmp_rle_pkg::PH_COUNT;
        do_check   = 1'b1;
      end
      default: ;
    endcase

    if (do_check && (off_next > OFF_W'(stride))) begin
      phase_next = bmp_rle_pkg::PH_HALT;
      res_valid  = 1'b1;
      st         = bmp_rle_pkg::ST_BAD;
    end
  end

  // row count as it stands after this edge; the row base is registered from it
  assign rows_ahead = advance ? rows_next : rows_done;

  // buffer bounds on the first and last byte touched
  assign a_s   = $signed(END_W'(row_base)) + $signed(END_W'(c_off));
  assign end_s = a_s + $signed(END_W'(p_span));
  assign drop  = !put_req || (a_s < 0) || (end_s > $signed(END_W'(limit)));

  always_comb begin
    res.status = st;
    if (drop) begin
      res.kind  = bmp_rle_pkg::KIND_NONE;
      res.addr  = '0;
      res.high  = 1'b0;
      res.units = 8'd0;
      res.data  = 8'd0;
    end else begin
      res.kind  = p_kind;
      res.addr  = a_s[bmp_rle_pkg::ADDR_W-1:0];
      res.high  = p_high;
      res.units = p_units;
      res.data  = p_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= bmp_rle_pkg::PH_COUNT;
      run_count    <= 8'd0;
      literal_left <= 8'd0;
      delta_dx     <= 8'd0;
      column_odd   <= 1'b0;
      row_offset   <= '0;
      rows_done    <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      run_count    <= run_next;
      literal_left <= lit_next;
      delta_dx     <= dx_next;
      column_odd   <= col_next;
      row_offset   <= off_next;
      rows_done    <= rows_next;
    end
  end

  `BRD_ASSERT_IMP(a_halt_quiet, advance && (phase == bmp_rle_pkg::PH_HALT) && !item_soi, !res_valid, "halted parser produced a result")
  `BRD_ASSERT_NXT(a_end_halts, advance && res_valid && (res.status != bmp_rle_pkg::ST_RUN), phase == bmp_rle_pkg::PH_HALT, "end or bad format did not halt")
  `BRD_ASSERT_IMP(a_nib_four, advance && res_valid && (res.kind == bmp_rle_pkg::KIND_NIBBLE), cfg.pixel_mode, "nibble store outside 4-bit mode")

endmodule
